// ----- hdl/lsv_pkg.sv -----
// ----------------------------------------------------------------------------
// lsv_pkg
// Shared types, constants and the pattern-to-error table of the line sensor
// vote and steering error block.
// ----------------------------------------------------------------------------
package lsv_pkg;

  localparam int unsigned SENSORS    = 10;
  localparam int unsigned HALF       = 5;
  localparam int unsigned STOPS      = 2;
  localparam int unsigned WINDOW_DEF = 5;

  localparam int unsigned CNT_W      = 3;
  localparam int unsigned WGT_W      = 4;
  localparam int unsigned ERR_W      = 5;
  localparam int unsigned RES_W      = 8;
  localparam int unsigned ACC_W      = 10;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 4;

  localparam int ERR_LIMIT = 120;

  localparam logic [CNT_W-1:0] THRESH_RST = CNT_W'(3);
  localparam logic [WGT_W-1:0] OPP_W_RST  = WGT_W'(3);
  localparam logic [WGT_W-1:0] SAME_W_RST = WGT_W'(5);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESH = 2'd0,
    CFG_OPP_W  = 2'd1,
    CFG_SAME_W = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [SENSORS-1:0] sensor_bits;
    logic [STOPS-1:0]   stop_bits;
    logic               front_primary;
  } lsv_in_t;

  typedef struct packed {
    logic signed [RES_W-1:0] error_tenths;
    logic                    line_lost;
    logic                    stop_first;
    logic                    stop_second;
    logic [SENSORS-1:0]      voted_sensors;
  } lsv_out_t;

  typedef struct packed {
    logic               last;
    logic [SENSORS-1:0] voted;
    logic               stop_first;
    logic               stop_second;
  } lsv_vote_t;

  typedef struct packed {
    logic                    hit;
    logic signed [ERR_W-1:0] val;
  } lsv_map_t;

  // Pattern bit k is pin k of the array; rear values are doubled near center.
  function automatic lsv_map_t lsv_map(input logic [HALF-1:0] pat, input logic rear);
    lsv_map_t m;
    m.hit = 1'b1;
    m.val = '0;
    unique case (pat)
      5'd31, 5'd4: m.val = 5'sd0;
      5'd6:        m.val = rear ? 5'sd2 : 5'sd1;
      5'd2:        m.val = rear ? 5'sd4 : 5'sd2;
      5'd3:        m.val = 5'sd6;
      5'd1:        m.val = 5'sd8;
      5'd12:       m.val = rear ? -5'sd2 : -5'sd1;
      5'd8:        m.val = rear ? -5'sd4 : -5'sd2;
      5'd24:       m.val = -5'sd6;
      5'd16:       m.val = -5'sd8;
      default:     m.hit = 1'b0;
    endcase
    return m;
  endfunction

endpackage

// ----- hdl/lsv_stream_if.sv -----
// ----------------------------------------------------------------------------
// lsv_stream_if
// Valid/ready stream channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface lsv_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/lsv_vote.sv -----
// ----------------------------------------------------------------------------
// lsv_vote
// Per-pin hit counters over a sample window and threshold vote.
// ----------------------------------------------------------------------------
module lsv_vote #(
  parameter int unsigned WINDOW = lsv_pkg::WINDOW_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step,
  input  logic [lsv_pkg::SENSORS-1:0]    sensor_bits,
  input  logic [lsv_pkg::STOPS-1:0]      stop_bits,
  input  logic [lsv_pkg::CNT_W-1:0]      threshold,
  output lsv_pkg::lsv_vote_t             vote
);
  import lsv_pkg::*;

  logic [CNT_W-1:0] hit_r    [SENSORS];
  logic [CNT_W-1:0] hit_nxt  [SENSORS];
  logic [CNT_W-1:0] stop_r   [STOPS];
  logic [CNT_W-1:0] stop_nxt [STOPS];
  logic [CNT_W-1:0] wc_r;
  logic [CNT_W-1:0] wc_nxt;
  logic [CNT_W-1:0] wc_inc;
  logic             fresh;
  logic [STOPS-1:0] stop_vote;

  always_comb begin
    fresh     = (wc_r == '0);
    wc_inc    = wc_r + CNT_W'(1);
    vote.last = (wc_inc == CNT_W'(WINDOW));
    wc_nxt    = vote.last ? '0 : wc_inc;
    for (int i = 0; i < SENSORS; i++) begin
      hit_nxt[i]    = (fresh ? '0 : hit_r[i]) + CNT_W'(sensor_bits[i]);
      vote.voted[i] = (hit_nxt[i] >= threshold);
    end
    for (int j = 0; j < STOPS; j++) begin
      stop_nxt[j]  = (fresh ? '0 : stop_r[j]) + CNT_W'(stop_bits[j]);
      stop_vote[j] = (stop_nxt[j] >= threshold);
    end
    vote.stop_first  = stop_vote[0];
    vote.stop_second = stop_vote[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wc_r <= '0;
      for (int i = 0; i < SENSORS; i++) hit_r[i] <= '0;
      for (int j = 0; j < STOPS; j++) stop_r[j] <= '0;
    end else if (step) begin
      wc_r <= wc_nxt;
      for (int i = 0; i < SENSORS; i++) hit_r[i] <= hit_nxt[i];
      for (int j = 0; j < STOPS; j++) stop_r[j] <= stop_nxt[j];
    end
  end

  a_wc_range: assert property (@(posedge clk) disable iff (!rst_n)
    wc_r < CNT_W'(WINDOW))
    else $error("window counter out of range");

  a_wc_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    step && vote.last |=> wc_r == '0)
    else $error("window did not restart after last sample");

  a_wc_count: assert property (@(posedge clk) disable iff (!rst_n)
    step && !vote.last |=> wc_r == $past(wc_inc))
    else $error("window counter skipped");

endmodule

// ----- hdl/lsv_err.sv -----
// ----------------------------------------------------------------------------
// lsv_err
// Front/rear pattern decode with held errors and combined steering error.
// ----------------------------------------------------------------------------
module lsv_err (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              fire,
  input  lsv_pkg::lsv_vote_t                vote,
  input  logic                              front_primary,
  input  logic [lsv_pkg::WGT_W-1:0]         opp_w,
  input  logic [lsv_pkg::WGT_W-1:0]         same_w,
  output logic signed [lsv_pkg::RES_W-1:0]  error_tenths,
  output logic                              line_lost
);
  import lsv_pkg::*;

  logic signed [ERR_W-1:0] fe_r;
  logic signed [ERR_W-1:0] re_r;
  lsv_map_t                fm;
  lsv_map_t                rm;
  logic signed [ERR_W-1:0] fe;
  logic signed [ERR_W-1:0] re;
  logic signed [ERR_W-1:0] prim;
  logic signed [ERR_W-1:0] sec;
  logic                    opp;
  logic [WGT_W-1:0]        wt;
  logic signed [ACC_W-1:0] wt_x;
  logic signed [ACC_W-1:0] sec_x;
  logic signed [ACC_W-1:0] prim_x;
  logic signed [ACC_W-1:0] base;
  logic signed [ACC_W-1:0] prod;
  logic signed [ACC_W-1:0] sum;
  logic signed [ACC_W-1:0] sat;

  always_comb begin
    fm     = lsv_map(vote.voted[HALF-1:0], 1'b0);
    rm     = lsv_map(vote.voted[SENSORS-1:HALF], 1'b1);
    fe     = fm.hit ? fm.val : fe_r;
    re     = rm.hit ? rm.val : re_r;
    opp    = (fe < 0 && re > 0) || (fe > 0 && re < 0);
    prim   = front_primary ? fe : re;
    sec    = front_primary ? re : fe;
    wt     = opp ? opp_w : same_w;
    wt_x   = $signed({{(ACC_W-WGT_W){1'b0}}, wt});
    sec_x  = ACC_W'(sec);
    prim_x = ACC_W'(prim);
    base   = (prim_x <<< 3) + (prim_x <<< 1);
    prod   = wt_x * sec_x;
    sum    = opp ? (base - prod) : (base + prod);
    if (sum > ACC_W'(ERR_LIMIT))
      sat = ACC_W'(ERR_LIMIT);
    else if (sum < -ACC_W'(ERR_LIMIT))
      sat = -ACC_W'(ERR_LIMIT);
    else
      sat = sum;
    line_lost    = (vote.voted == '0);
    error_tenths = line_lost ? '0 : sat[RES_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fe_r <= '0;
      re_r <= '0;
    end else if (fire) begin
      fe_r <= fe;
      re_r <= re;
    end
  end

endmodule

// ----- hdl/line_sensor_vote_and_error_top.sv -----
// ----------------------------------------------------------------------------
// line_sensor_vote_and_error_top
// Windowed threshold vote of ten line and two stop sensors, with a combined
// front/rear steering error in tenths on the last sample of each window.
//
//   channel  dir  handshake         payload
//   in_if    in   valid/ready       sensor_bits, stop_bits, front_primary
//   out_if   out  valid/ready       error_tenths, line_lost, stop_first,
//                                   stop_second, voted_sensors
//   cfg_*    in   cfg_we            cfg_idx, cfg_wdata (write only)
//
// One sample transaction per cycle unless stalled; the last sample of a window
// passes the input register, then the result register, before its result leaves.
// Synchronous active-low reset clears counters, held errors and valid flags.
// A stalled result stalls only samples that close a window; mid-window
// samples keep flowing.
// ----------------------------------------------------------------------------
module line_sensor_vote_and_error_top #(
  parameter int unsigned WINDOW = lsv_pkg::WINDOW_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  lsv_stream_if.sink                      in_if,
  lsv_stream_if.source                    out_if,
  input  logic                            cfg_we,
  input  logic [lsv_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [lsv_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import lsv_pkg::*;

  logic [CNT_W-1:0]        thresh_r;
  logic [WGT_W-1:0]        opp_w_r;
  logic [WGT_W-1:0]        same_w_r;
  logic                    st_valid_r;
  lsv_in_t                 st_r;
  logic                    out_valid_r;
  lsv_out_t                out_r;
  logic                    out_free;
  logic                    adv;
  logic                    fire;
  lsv_vote_t               vote;
  logic signed [RES_W-1:0] err_tenths;
  logic                    lost;

  lsv_vote #(.WINDOW(WINDOW)) u_vote (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (adv),
    .sensor_bits (st_r.sensor_bits),
    .stop_bits   (st_r.stop_bits),
    .threshold   (thresh_r),
    .vote        (vote)
  );

  lsv_err u_err (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (fire),
    .vote          (vote),
    .front_primary (st_r.front_primary),
    .opp_w         (opp_w_r),
    .same_w        (same_w_r),
    .error_tenths  (err_tenths),
    .line_lost     (lost)
  );

  assign out_free     = !out_valid_r || out_if.ready;
  assign adv          = st_valid_r && (out_free || !vote.last);
  assign fire         = adv && vote.last;
  assign in_if.ready  = !st_valid_r || adv;
  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RST;
      opp_w_r  <= OPP_W_RST;
      same_w_r <= SAME_W_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_THRESH: thresh_r <= cfg_wdata[CNT_W-1:0];
        CFG_OPP_W:  opp_w_r  <= cfg_wdata[WGT_W-1:0];
        CFG_SAME_W: same_w_r <= cfg_wdata[WGT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r <= 1'b0;
    end else if (in_if.valid && in_if.ready) begin
      st_valid_r <= 1'b1;
    end else if (adv) begin
      st_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      st_r <= in_if.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r.error_tenths  <= err_tenths;
      out_r.line_lost     <= lost;
      out_r.stop_first    <= vote.stop_first;
      out_r.stop_second   <= vote.stop_second;
      out_r.voted_sensors <= vote.voted;
    end
  end

  a_lost_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.line_lost |-> out_r.error_tenths == '0)
    else $error("line lost with nonzero error");

  a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($signed(out_r.error_tenths) >= -ERR_LIMIT &&
                     $signed(out_r.error_tenths) <= ERR_LIMIT))
    else $error("steering error out of range");

  a_lost_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.line_lost == (out_r.voted_sensors == '0))
    else $error("line lost flag disagrees with voted sensors");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    st_valid_r && !adv |=> st_valid_r && $stable(st_r))
    else $error("stalled sample dropped or changed");

endmodule
